[rtl/bmprle_pkg.sv]
package bmprle_pkg;

   // Size limits of the frame buffer that the spans address.
   localparam int MAX_ROW_BYTES = 4096;
   localparam int MAX_ROWS      = 4096;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int PHASE_W = 3;
   localparam int COL_W   = 13;
   localparam int ROW_W   = 12;
   localparam int ADDR_W  = 24;
   localparam int RB_W    = 13;
   localparam int LIM_W   = 17;
   localparam int PROD_W  = ROW_W + RB_W;

   localparam logic [COL_W-1:0] COL_TOP = 13'd8191;
   localparam logic [ROW_W-1:0] ROW_TOP = 12'd4095;

   // Parse phases.
   localparam logic [PHASE_W-1:0] PH_COUNT  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SECOND = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DX     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DY     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LIT    = 3'd4;
   localparam logic [PHASE_W-1:0] PH_PAD    = 3'd5;

   // Escape commands that follow a zero count byte.
   localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
   localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
   localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_FILL  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LIT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EOB   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EARLY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RANGE = 3'd4;

   // Register file.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES  = 1'd1;
   localparam logic [RB_W-1:0]      ROW_BYTES_RESET = 13'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_image;
      logic              stream_end;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] pixel_count;
      logic [BYTE_W-1:0] pixel_value;
   } result_type;

   typedef struct packed {
      logic            pixel_mode;
      logic [RB_W-1:0] row_bytes;
   } cfg_type;

endpackage

[rtl/bmprle_in_stage.sv]
module bmprle_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bmprle_pkg::item_type  req_item,
   input  logic                  step,
   output logic                  item_valid,
   output bmprle_pkg::item_type  item
);

   logic                 valid_ff;
   logic                 valid_in;
   bmprle_pkg::item_type item_ff;

   // The register is free when empty or when its item is consumed this cycle.
   assign req_ready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/bmprle_decode.sv]
module bmprle_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bmprle_pkg::item_type   item,
   input  bmprle_pkg::cfg_type    cfg,
   output logic                   res_valid,
   output bmprle_pkg::result_type res
);

   // Decoder state.
   logic [bmprle_pkg::PHASE_W-1:0] phase_ff,   phase_in;
   logic [bmprle_pkg::BYTE_W-1:0]  held_ff,    held_in;
   logic [bmprle_pkg::COL_W-1:0]   col_ff,     col_in;
   logic [bmprle_pkg::ROW_W-1:0]   row_ff,     row_in;
   logic [bmprle_pkg::BYTE_W-1:0]  rem_ff,     rem_in;
   logic                           pad_ff,     pad_in;
   logic                           done_ff,    done_in;
   logic                           col_ovf_ff, col_ovf_in;
   logic                           row_ovf_ff, row_ovf_in;

   // State as seen by this item: start of image clears it first.
   logic [bmprle_pkg::PHASE_W-1:0] cur_phase;
   logic [bmprle_pkg::BYTE_W-1:0]  cur_held;
   logic [bmprle_pkg::COL_W-1:0]   cur_col;
   logic [bmprle_pkg::ROW_W-1:0]   cur_row;
   logic [bmprle_pkg::BYTE_W-1:0]  cur_rem;
   logic                           cur_pad;
   logic                           cur_done;
   logic                           cur_col_ovf;
   logic                           cur_row_ovf;

   logic [bmprle_pkg::BYTE_W-1:0]  b;
   logic [bmprle_pkg::BYTE_W-1:0]  lit_cnt;
   logic [bmprle_pkg::BYTE_W-1:0]  rem_eff;

   // Shared span unit.
   logic                           use_span;
   logic [bmprle_pkg::KIND_W-1:0]  span_kind;
   logic [bmprle_pkg::BYTE_W-1:0]  span_count;
   logic [bmprle_pkg::COL_W:0]     span_last;
   logic [bmprle_pkg::COL_W:0]     last_off;
   logic [bmprle_pkg::COL_W-1:0]   first_off;
   logic [bmprle_pkg::LIM_W-1:0]   limit;
   logic [bmprle_pkg::PROD_W-1:0]  prod;
   logic [bmprle_pkg::PROD_W:0]    addr_sum;
   logic                           span_bad;

   // Cursor adders.
   logic                           col_add;
   logic                           col_clear;
   logic [bmprle_pkg::BYTE_W-1:0]  col_amt;
   logic [bmprle_pkg::COL_W:0]     col_sum;
   logic                           row_add;
   logic [bmprle_pkg::BYTE_W-1:0]  row_amt;
   logic [bmprle_pkg::ROW_W:0]     row_sum;
   logic                           eob;

   assign b = item.data_byte;

   always_comb begin
      if (item.start_of_image) begin
         cur_phase   = bmprle_pkg::PH_COUNT;
         cur_held    = '0;
         cur_col     = '0;
         cur_row     = '0;
         cur_rem     = '0;
         cur_pad     = 1'b0;
         cur_done    = 1'b0;
         cur_col_ovf = 1'b0;
         cur_row_ovf = 1'b0;
      end else begin
         cur_phase   = phase_ff;
         cur_held    = held_ff;
         cur_col     = col_ff;
         cur_row     = row_ff;
         cur_rem     = rem_ff;
         cur_pad     = pad_ff;
         cur_done    = done_ff;
         cur_col_ovf = col_ovf_ff;
         cur_row_ovf = row_ovf_ff;
      end
   end

   // In 4-bit mode a literal byte carries two pixels unless only one is left.
   assign lit_cnt = (cfg.pixel_mode && cur_rem >= 8'd2) ? 8'd2 : 8'd1;
   assign rem_eff = (cur_rem == '0) ? lit_cnt : cur_rem;

   assign span_count = (cur_phase == bmprle_pkg::PH_LIT) ? lit_cnt : cur_held;
   assign span_kind  = (cur_phase == bmprle_pkg::PH_LIT) ? bmprle_pkg::KIND_LIT
                                                         : bmprle_pkg::KIND_FILL;

   always_comb begin
      span_last = {1'b0, cur_col} + (bmprle_pkg::COL_W+1)'(span_count) - 14'd1;
      if (cfg.pixel_mode) begin
         first_off = cur_col >> 1;
         last_off  = span_last >> 1;
      end else begin
         first_off = cur_col;
         last_off  = span_last;
      end
      if (bmprle_pkg::LIM_W'(cfg.row_bytes) > bmprle_pkg::LIM_W'(bmprle_pkg::MAX_ROW_BYTES)) begin
         limit = bmprle_pkg::LIM_W'(bmprle_pkg::MAX_ROW_BYTES);
      end else begin
         limit = bmprle_pkg::LIM_W'(cfg.row_bytes);
      end
      span_bad = cur_col_ovf || cur_row_ovf ||
                 span_last > (bmprle_pkg::COL_W+1)'(bmprle_pkg::COL_TOP) ||
                 bmprle_pkg::LIM_W'(cur_row) >= bmprle_pkg::LIM_W'(bmprle_pkg::MAX_ROWS) ||
                 bmprle_pkg::LIM_W'(last_off) >= limit;
      prod     = bmprle_pkg::PROD_W'(cur_row) * bmprle_pkg::PROD_W'(cfg.row_bytes);
      addr_sum = (bmprle_pkg::PROD_W+1)'(prod) + (bmprle_pkg::PROD_W+1)'(first_off);
   end

   always_comb begin
      phase_in   = cur_phase;
      held_in    = cur_held;
      rem_in     = cur_rem;
      pad_in     = cur_pad;
      done_in    = cur_done;
      use_span   = 1'b0;
      col_add    = 1'b0;
      col_clear  = 1'b0;
      col_amt    = '0;
      row_add    = 1'b0;
      row_amt    = '0;
      eob        = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (!cur_done) begin
         case (cur_phase)
            bmprle_pkg::PH_SECOND: begin
               phase_in = bmprle_pkg::PH_COUNT;
               if (cur_held != '0) begin
                  use_span = 1'b1;
               end else begin
                  case (b)
                     bmprle_pkg::ESC_EOL: begin
                        col_clear = 1'b1;
                        row_add   = 1'b1;
                        row_amt   = 8'd1;
                     end
                     bmprle_pkg::ESC_EOB: begin
                        eob     = 1'b1;
                        done_in = 1'b1;
                     end
                     bmprle_pkg::ESC_DELTA: begin
                        phase_in = bmprle_pkg::PH_DX;
                     end
                     default: begin
                        rem_in   = b;
                        phase_in = bmprle_pkg::PH_LIT;
                        if (cfg.pixel_mode) begin
                           pad_in = (b[1:0] == 2'd1) || (b[1:0] == 2'd2);
                        end else begin
                           pad_in = b[0];
                        end
                     end
                  endcase
               end
            end
            bmprle_pkg::PH_DX: begin
               held_in  = b;
               phase_in = bmprle_pkg::PH_DY;
            end
            bmprle_pkg::PH_DY: begin
               col_add  = 1'b1;
               col_amt  = cur_held;
               row_add  = 1'b1;
               row_amt  = b;
               phase_in = bmprle_pkg::PH_COUNT;
            end
            bmprle_pkg::PH_LIT: begin
               use_span = 1'b1;
               rem_in   = rem_eff - lit_cnt;
               if (rem_eff == lit_cnt) begin
                  phase_in = cur_pad ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
               end
            end
            bmprle_pkg::PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = bmprle_pkg::PH_COUNT;
            end
            default: begin
               held_in  = b;
               phase_in = bmprle_pkg::PH_SECOND;
            end
         endcase
      end

      if (use_span) begin
         col_add = 1'b1;
         col_amt = span_count;
      end

      // Column cursor saturates and flags overflow; end of line rewinds it.
      col_sum    = {1'b0, cur_col} + (bmprle_pkg::COL_W+1)'(col_amt);
      col_in     = cur_col;
      col_ovf_in = cur_col_ovf;
      if (col_clear) begin
         col_in     = '0;
         col_ovf_in = 1'b0;
      end else if (col_add) begin
         if (col_sum > (bmprle_pkg::COL_W+1)'(bmprle_pkg::COL_TOP)) begin
            col_in     = bmprle_pkg::COL_TOP;
            col_ovf_in = 1'b1;
         end else begin
            col_in = col_sum[bmprle_pkg::COL_W-1:0];
         end
      end

      row_sum    = {1'b0, cur_row} + (bmprle_pkg::ROW_W+1)'(row_amt);
      row_in     = cur_row;
      row_ovf_in = cur_row_ovf;
      if (row_add) begin
         if (row_sum > (bmprle_pkg::ROW_W+1)'(bmprle_pkg::ROW_TOP)) begin
            row_in     = bmprle_pkg::ROW_TOP;
            row_ovf_in = 1'b1;
         end else begin
            row_in = row_sum[bmprle_pkg::ROW_W-1:0];
         end
      end

      if (use_span) begin
         res_valid       = 1'b1;
         res.kind        = span_bad ? bmprle_pkg::KIND_RANGE : span_kind;
         res.row         = cur_row;
         res.column      = cur_col;
         res.byte_address = span_bad ? '0 : addr_sum[bmprle_pkg::ADDR_W-1:0];
         res.pixel_count = span_count;
         res.pixel_value = b;
      end

      if (eob) begin
         res_valid  = 1'b1;
         res.kind   = bmprle_pkg::KIND_EOB;
         res.row    = cur_row;
         res.column = cur_col;
      end else if (!cur_done && item.stream_end) begin
         // A truncated stream replaces any span with an error at the new cursor.
         res_valid  = 1'b1;
         res        = '0;
         res.kind   = bmprle_pkg::KIND_EARLY;
         res.row    = row_in;
         res.column = col_in;
         done_in    = 1'b1;
         phase_in   = bmprle_pkg::PH_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bmprle_pkg::PH_COUNT;
         held_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         rem_ff     <= '0;
         pad_ff     <= 1'b0;
         done_ff    <= 1'b0;
         col_ovf_ff <= 1'b0;
         row_ovf_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         rem_ff     <= rem_in;
         pad_ff     <= pad_in;
         done_ff    <= done_in;
         col_ovf_ff <= col_ovf_in;
         row_ovf_ff <= row_ovf_in;
      end
   end

   a_eob_sets_done: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.kind == bmprle_pkg::KIND_EOB |=> done_ff)
      else $error("end of bitmap did not mark the bitmap done");

   a_done_is_silent: assert property (@(posedge clock) disable iff (reset)
      step && done_ff && !item.start_of_image |-> !res_valid)
      else $error("result produced after the bitmap was done");

   a_range_no_address: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == bmprle_pkg::KIND_RANGE |-> res.byte_address == '0)
      else $error("out of range span carries an address");

   a_overflow_is_range: assert property (@(posedge clock) disable iff (reset)
      step && use_span && (cur_col_ovf || cur_row_ovf) |->
      res.kind == bmprle_pkg::KIND_RANGE || res.kind == bmprle_pkg::KIND_EARLY)
      else $error("span written with an overflowed cursor");

endmodule

[rtl/bmprle_out_stage.sv]
module bmprle_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bmprle_pkg::result_type res,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bmprle_pkg::result_type rsp_res
);

   logic                   valid_ff;
   logic                   valid_in;
   bmprle_pkg::result_type res_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

[rtl/bmp_rle_decoder.sv]
// Bitmap RLE8 / RLE4 stream decoder. One compressed byte is taken per item and
// turned into at most one span command for a frame-buffer writer: a fill run,
// one literal byte of an absolute run, end of bitmap, an unexpected-end error,
// or an out-of-range report when the span would fall outside the row or image
// limits (the cursor still advances, but the writer should drop the span).
// The block sustains one item per clock cycle while the result side keeps
// taking items; an item passes through the input register and then the
// result register, with the single decode stage between them. The
// row-times-row_bytes product and the cursor adders sit in that stage.
// Configuration (csr index 0 pixel_mode, index 1 row_bytes) must only
// be written while the decoder holds no item.
module bmp_rle_decoder (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bmprle_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                                req_start_of_image,
   input  logic                                req_stream_end,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bmprle_pkg::KIND_W-1:0]       rsp_kind,
   output logic [bmprle_pkg::ROW_W-1:0]        rsp_row,
   output logic [bmprle_pkg::COL_W-1:0]        rsp_column,
   output logic [bmprle_pkg::ADDR_W-1:0]       rsp_byte_address,
   output logic [bmprle_pkg::BYTE_W-1:0]       rsp_pixel_count,
   output logic [bmprle_pkg::BYTE_W-1:0]       rsp_pixel_value,

   input  logic                                csr_write_enable,
   input  logic [bmprle_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmprle_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   bmprle_pkg::item_type   req_item;
   bmprle_pkg::item_type   item;
   bmprle_pkg::result_type res;
   bmprle_pkg::result_type rsp_res;
   bmprle_pkg::cfg_type    cfg;

   logic                        item_valid;
   logic                        slot_free;
   logic                        step;
   logic                        res_valid;

   logic                        pixel_mode_ff;
   logic                        pixel_mode_in;
   logic [bmprle_pkg::RB_W-1:0] row_bytes_ff;
   logic [bmprle_pkg::RB_W-1:0] row_bytes_in;

   // Configuration registers. A write to an unlisted index is ignored.
   always_comb begin
      pixel_mode_in = pixel_mode_ff;
      row_bytes_in  = row_bytes_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bmprle_pkg::CSR_PIXEL_MODE: pixel_mode_in = csr_write_data[0];
            bmprle_pkg::CSR_ROW_BYTES:  row_bytes_in  = csr_write_data[bmprle_pkg::RB_W-1:0];
            default: begin
               pixel_mode_in = pixel_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff <= 1'b0;
         row_bytes_ff  <= bmprle_pkg::ROW_BYTES_RESET;
      end else begin
         pixel_mode_ff <= pixel_mode_in;
         row_bytes_ff  <= row_bytes_in;
      end
   end

   assign cfg.pixel_mode = pixel_mode_ff;
   assign cfg.row_bytes  = row_bytes_ff;

   assign req_item.data_byte      = req_data_byte;
   assign req_item.start_of_image = req_start_of_image;
   assign req_item.stream_end     = req_stream_end;

   // The held item is decoded whenever the result register can take the
   // outcome, so a byte that gives no result still moves at full rate.
   assign step = item_valid && slot_free;

   bmprle_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   bmprle_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   bmprle_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind         = rsp_res.kind;
   assign rsp_row          = rsp_res.row;
   assign rsp_column       = rsp_res.column;
   assign rsp_byte_address = rsp_res.byte_address;
   assign rsp_pixel_count  = rsp_res.pixel_count;
   assign rsp_pixel_value  = rsp_res.pixel_value;

endmodule

[tb/sv/bmp_rle_decoder_tb.sv]
`timescale 1ns / 1ps

module bmp_rle_decoder_tb;
   import bmprle_pkg::*;

   // The count byte of zero that introduces every escape command.
   localparam logic [BYTE_W-1:0] ESC_LEAD = 8'h00;
   // Global watchdog, far above the slowest legal run of this stimulus.
   localparam int CYCLE_LIMIT = 400000;
   // Random bytes per configuration phase and the number of phases.
   localparam int PHASE_BYTES = 125;
   localparam int NUM_PHASES  = 8;
   // Cycles the receiver holds off once, to make the decoder back up.
   localparam int LONG_HOLD = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_start_of_image = 1'b0;
   logic                  req_stream_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [ROW_W-1:0]      rsp_row;
   logic [COL_W-1:0]      rsp_column;
   logic [ADDR_W-1:0]     rsp_byte_address;
   logic [BYTE_W-1:0]     rsp_pixel_count;
   logic [BYTE_W-1:0]     rsp_pixel_value;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bmp_rle_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_start_of_image (req_start_of_image),
      .req_stream_end     (req_stream_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_row            (rsp_row),
      .rsp_column         (rsp_column),
      .rsp_byte_address   (rsp_byte_address),
      .rsp_pixel_count    (rsp_pixel_count),
      .rsp_pixel_value    (rsp_pixel_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Compressed bytes waiting to be offered, and spans still owed by the decoder.
   item_type   byte_queue[$];
   result_type expected_spans[$];

   int errors = 0;
   int cycles = 0;
   // The driver counts items it has put on the bus; the acceptance process counts
   // the ones taken. While the two differ, the current item must stay on the bus.
   int offered_cnt = 0;
   int accepted_cnt = 0;

   // Our own copy of the decoder's registers and parse state.
   logic              cfg_mode = 1'b0;
   logic [RB_W-1:0]   cfg_row_bytes = ROW_BYTES_RESET;
   logic [PHASE_W-1:0] ph = PH_COUNT;
   logic [BYTE_W-1:0] held = '0;
   logic [COL_W-1:0]  cur_col = '0;
   logic [ROW_W-1:0]  cur_row = '0;
   logic [BYTE_W-1:0] lit_left = '0;
   logic              pad_due = 1'b0;
   logic              img_done = 1'b0;
   logic              col_sat = 1'b0;
   logic              row_sat = 1'b0;

   // ------------------------------------------------------------------------
   // Span predictor
   // ------------------------------------------------------------------------

   function automatic void clear_image();
      ph = PH_COUNT;
      held = '0;
      cur_col = '0;
      cur_row = '0;
      lit_left = '0;
      pad_due = 1'b0;
      img_done = 1'b0;
      col_sat = 1'b0;
      row_sat = 1'b0;
   endfunction

   // The cursor saturates rather than wraps; going past the top marks it overflowed,
   // after which every span is reported out of range until it is cleared.
   function automatic void step_col(input int unsigned n);
      int unsigned c;
      c = 32'(cur_col) + n;
      if (c > COL_TOP) begin
         c = COL_TOP;
         col_sat = 1'b1;
      end
      cur_col = c[COL_W-1:0];
   endfunction

   function automatic void step_row(input int unsigned n);
      int unsigned r;
      r = 32'(cur_row) + n;
      if (r > ROW_TOP) begin
         r = ROW_TOP;
         row_sat = 1'b1;
      end
      cur_row = r[ROW_W-1:0];
   endfunction

   // Row and column always reflect the cursor at the moment the span is formed.
   function automatic result_type make_span(input logic [KIND_W-1:0] kind,
                                            input int unsigned addr,
                                            input int unsigned cnt,
                                            input logic [BYTE_W-1:0] val);
      result_type r;
      r.kind = kind;
      r.row = cur_row;
      r.column = cur_col;
      r.byte_address = addr[ADDR_W-1:0];
      r.pixel_count = cnt[BYTE_W-1:0];
      r.pixel_value = val;
      return r;
   endfunction

   // A fill run or literal byte at the cursor. In 4-bit mode two pixels share a
   // byte, so the byte offset is half the column. The cursor moves on even when
   // the span falls outside the frame and is reported as out of range.
   function automatic result_type emit_span(input logic [KIND_W-1:0] kind,
                                            input int unsigned cnt,
                                            input logic [BYTE_W-1:0] val);
      result_type  r;
      int unsigned lim;
      int unsigned last_px;
      int unsigned first_off;
      int unsigned last_off;
      int unsigned addr;
      lim = 32'(cfg_row_bytes);
      if (lim > MAX_ROW_BYTES)
         lim = MAX_ROW_BYTES;
      last_px = 32'(cur_col) + cnt - 1;
      first_off = cfg_mode ? (int'(cur_col) >> 1) : int'(cur_col);
      last_off = cfg_mode ? (last_px >> 1) : last_px;
      if (col_sat || row_sat || last_px > COL_TOP || cur_row >= MAX_ROWS ||
          last_off >= lim) begin
         r = make_span(KIND_RANGE, 0, cnt, val);
      end else begin
         addr = int'(cur_row) * int'(cfg_row_bytes) + first_off;
         r = make_span(kind, addr, cnt, val);
      end
      step_col(cnt);
      return r;
   endfunction

   // Applies one accepted byte to the parse state and queues the span it owes.
   function automatic void decode_byte(input item_type it);
      result_type        r;
      bit                made;
      int unsigned       cnt;
      logic [BYTE_W-1:0] b;
      b = it.data_byte;
      made = 1'b0;
      r = '0;
      if (it.start_of_image)
         clear_image();
      // Once a bitmap has ended, everything up to the next start is dropped.
      if (img_done)
         return;
      case (ph)
         PH_SECOND: begin
            if (held != '0) begin
               r = emit_span(KIND_FILL, 32'(held), b);
               made = 1'b1;
               ph = PH_COUNT;
            end else if (b == ESC_EOL) begin
               cur_col = '0;
               col_sat = 1'b0;
               step_row(1);
               ph = PH_COUNT;
            end else if (b == ESC_EOB) begin
               // End of bitmap wins even over stream_end on the same byte.
               expected_spans.push_back(make_span(KIND_EOB, 0, 0, '0));
               img_done = 1'b1;
               ph = PH_COUNT;
               return;
            end else if (b == ESC_DELTA) begin
               ph = PH_DX;
            end else begin
               lit_left = b;
               if (cfg_mode)
                  pad_due = (b[1:0] == 2'd1) || (b[1:0] == 2'd2);
               else
                  pad_due = b[0];
               ph = PH_LIT;
            end
         end
         PH_DX: begin
            held = b;
            ph = PH_DY;
         end
         PH_DY: begin
            step_col(32'(held));
            step_row(32'(b));
            ph = PH_COUNT;
         end
         PH_LIT: begin
            cnt = (cfg_mode && lit_left >= 2) ? 2 : 1;
            if (lit_left == '0)
               lit_left = cnt[BYTE_W-1:0];
            r = emit_span(KIND_LIT, cnt, b);
            made = 1'b1;
            lit_left = lit_left - cnt[BYTE_W-1:0];
            if (lit_left == '0)
               ph = pad_due ? PH_PAD : PH_COUNT;
         end
         PH_PAD: begin
            pad_due = 1'b0;
            ph = PH_COUNT;
         end
         default: begin
            held = b;
            ph = PH_SECOND;
         end
      endcase
      // A premature end replaces whatever span this byte would have produced,
      // reporting the cursor after the byte has taken effect.
      if (it.stream_end) begin
         r = make_span(KIND_EARLY, 0, 0, '0);
         made = 1'b1;
         img_done = 1'b1;
         ph = PH_COUNT;
      end
      if (made)
         expected_spans.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic soi,
                                    input logic eos);
      item_type it;
      it.data_byte = b;
      it.start_of_image = soi;
      it.stream_end = eos;
      byte_queue.push_back(it);
   endfunction

   // Mostly short idles, now and then a long one; none at all while calm.
   function automatic int gap_len(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Garbage bytes with random control flags, to hit odd phases and restarts.
   function automatic void add_noise(input int n);
      for (int k = 0; k < n; k++)
         add_byte(8'($urandom), ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0));
   endfunction

   // A well-formed bitmap with random content. A heavy one walks the cursor
   // past both saturation points with large deltas before drawing anything.
   // Some bitmaps are cut short by stream_end on a random byte.
   function automatic void add_image(input bit heavy);
      int          first;
      int          ops;
      int          cnt;
      int          nbytes;
      int          cut;
      item_type    it;
      first = byte_queue.size();
      if (heavy) begin
         for (int k = 0; k < 36; k++) begin
            add_byte(ESC_LEAD, 1'b0, 1'b0);
            add_byte(ESC_DELTA, 1'b0, 1'b0);
            add_byte(8'($urandom_range(230, 255)), 1'b0, 1'b0);
            add_byte(8'($urandom_range(200, 255)), 1'b0, 1'b0);
         end
      end
      ops = $urandom_range(2, 10);
      for (int k = 0; k < ops; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                 : $urandom_range(1, 6);
               add_byte(8'(cnt), 1'b0, 1'b0);
               add_byte(8'($urandom), 1'b0, 1'b0);
            end
            4, 5, 6: begin
               cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 80)
                                                  : $urandom_range(3, 9);
               add_byte(ESC_LEAD, 1'b0, 1'b0);
               add_byte(8'(cnt), 1'b0, 1'b0);
               nbytes = cfg_mode ? (cnt + 1) / 2 : cnt;
               for (int j = 0; j < nbytes; j++)
                  add_byte(8'($urandom), 1'b0, 1'b0);
               if (cfg_mode ? ((cnt % 4) == 1 || (cnt % 4) == 2) : (cnt % 2) == 1)
                  add_byte(8'($urandom), 1'b0, 1'b0);
            end
            7: begin
               add_byte(ESC_LEAD, 1'b0, 1'b0);
               add_byte(ESC_DELTA, 1'b0, 1'b0);
               add_byte(8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 8)),
                        1'b0, 1'b0);
               add_byte(8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3)),
                        1'b0, 1'b0);
            end
            8: begin
               add_byte(ESC_LEAD, 1'b0, 1'b0);
               add_byte(ESC_EOL, 1'b0, 1'b0);
            end
            default: add_byte(8'($urandom), 1'b0, 1'b0);
         endcase
      end
      add_byte(ESC_LEAD, 1'b0, 1'b0);
      add_byte(ESC_EOB, 1'b0, ($urandom_range(0, 3) == 0));
      it = byte_queue[first];
      it.start_of_image = 1'b1;
      byte_queue[first] = it;
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(first, byte_queue.size() - 1);
         while (byte_queue.size() > cut + 1)
            void'(byte_queue.pop_back());
         it = byte_queue[cut];
         it.stream_end = 1'b1;
         byte_queue[cut] = it;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: the payload changes at the falling edge, and an item counts as
   // taken at the rising edge where valid and ready are both high.
   // ------------------------------------------------------------------------

   int       send_gap = 0;
   bit       send_calm = 1'b0;
   item_type offer_item;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         decode_byte('{req_data_byte, req_start_of_image, req_stream_end});
         accepted_cnt = accepted_cnt + 1;
      end
   end

   always @(negedge clock) begin
      // An item on the bus that has not been taken stays there untouched.
      if (!reset && offered_cnt == accepted_cnt) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (byte_queue.size() > 0) begin
            offer_item = byte_queue.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= offer_item.data_byte;
            req_start_of_image <= offer_item.start_of_image;
            req_stream_end <= offer_item.stream_end;
            offered_cnt = offered_cnt + 1;
            if ($urandom_range(0, 63) == 0)
               send_calm = !send_calm;
            send_gap = gap_len(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off in the middle of
   // the run while plenty of bytes are still queued, so that the decoder fills
   // up and has to drop req_ready.
   // ------------------------------------------------------------------------

   int recv_stall = 0;
   bit recv_calm = 1'b0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_cnt >= 500 && byte_queue.size() > 50) begin
            hold_done = 1'b1;
            recv_stall = LONG_HOLD;
         end
         if (recv_stall > 0) begin
            rsp_ready <= 1'b0;
            recv_stall = recv_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
               recv_calm = !recv_calm;
            recv_stall = gap_len(recv_calm);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every span taken is matched against the oldest expectation.
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors = errors + 1;
      end
   endtask

   result_type want_span;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_spans.size() == 0) begin
            $display("%0t: unexpected span, expected none, actual kind %0d row %0d col %0d",
                     $time, rsp_kind, rsp_row, rsp_column);
            errors = errors + 1;
         end else begin
            want_span = expected_spans.pop_front();
            check_field("kind", 32'(want_span.kind), 32'(rsp_kind));
            check_field("row", 32'(want_span.row), 32'(rsp_row));
            check_field("column", 32'(want_span.column), 32'(rsp_column));
            check_field("byte_address", 32'(want_span.byte_address),
                        32'(rsp_byte_address));
            check_field("pixel_count", 32'(want_span.pixel_count),
                        32'(rsp_pixel_count));
            check_field("pixel_value", 32'(want_span.pixel_value),
                        32'(rsp_pixel_value));
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------

   // Register writes go through here so our copy of the registers follows.
   // Only called while the decoder holds nothing.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_PIXEL_MODE)
         cfg_mode = data[0];
      else
         cfg_row_bytes = data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every queued byte is taken and every owed span has come back.
   // Bytes like pad or delta leave no span, so the task then waits longer to let the last
   // of them clear the two-stage pipeline.
   task automatic wait_idle();
      while (byte_queue.size() != 0 || offered_cnt != accepted_cnt ||
             expected_spans.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Settings per phase: both modes, the smallest and largest legal row widths,
   // a width of zero, a width beyond the frame limit and one not a multiple of four.
   logic [RB_W-1:0] phase_rb[NUM_PHASES] = '{13'd256, 13'd64, 13'd4, 13'd4096,
                                             13'd0, 13'd8191, 13'd1003, 13'd32};
   bit              phase_mode[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                               1'b1, 1'b0, 1'b1, 1'b0};

   initial begin
      logic [CSR_DATA_W-1:0] mode_word;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part in 8-bit mode with a narrow 16-byte row.
      write_csr(CSR_PIXEL_MODE, '0);
      write_csr(CSR_ROW_BYTES, 13'd16);
      add_byte(8'd3, 1'b1, 1'b0);          // fill run of three
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(ESC_LEAD, 1'b0, 1'b0);      // odd absolute run with a pad byte
      add_byte(8'd3, 1'b0, 1'b0);
      add_byte(8'hAA, 1'b0, 1'b0);
      add_byte(8'h55, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(ESC_LEAD, 1'b0, 1'b0);      // delta
      add_byte(ESC_DELTA, 1'b0, 1'b0);
      add_byte(8'd5, 1'b0, 1'b0);
      add_byte(8'd1, 1'b0, 1'b0);
      add_byte(ESC_LEAD, 1'b0, 1'b0);      // end of line
      add_byte(ESC_EOL, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);         // run far past the row: out of range
      add_byte(8'h12, 1'b0, 1'b0);
      add_byte(ESC_LEAD, 1'b0, 1'b0);      // end of bitmap
      add_byte(ESC_EOB, 1'b0, 1'b0);
      add_byte(8'h07, 1'b0, 1'b0);         // ignored after the end
      add_byte(8'd2, 1'b1, 1'b0);          // new bitmap cut off mid-run
      add_byte(8'h34, 1'b0, 1'b1);
      add_byte(ESC_LEAD, 1'b1, 1'b0);      // end of bitmap flagged as last byte
      add_byte(ESC_EOB, 1'b0, 1'b1);
      wait_idle();

      // Random phases. Upper bits of the mode word are junk the decoder drops.
      for (int p = 0; p < NUM_PHASES; p++) begin
         mode_word = CSR_DATA_W'($urandom);
         mode_word[0] = phase_mode[p];
         write_csr(CSR_PIXEL_MODE, mode_word);
         write_csr(CSR_ROW_BYTES, phase_rb[p]);
         if (p == 3 || p == 5)
            add_image(1'b1);
         while (byte_queue.size() < PHASE_BYTES) begin
            if ($urandom_range(0, 9) == 0)
               add_noise($urandom_range(2, 8));
            else
               add_image(1'b0);
         end
         wait_idle();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
rtl/bmprle_pkg.sv
rtl/bmprle_in_stage.sv
rtl/bmprle_decode.sv
rtl/bmprle_out_stage.sv
rtl/bmp_rle_decoder.sv
tb/sv/bmp_rle_decoder_tb.sv
